// ===== src/mhbir_pkg.sv =====
// ----------------------------------------------------------------------------
// mhbir_pkg
// Shared types and constants for the max-heap block: action codes, datapath
// operation codes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package mhbir_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CAP_W     = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_BUILD  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_APPEND,
    OP_RM_SWAP,
    OP_RB_INIT,
    OP_SD_CAPP,
    OP_SD_CAPR,
    OP_SD_STEP,
    OP_EM_INIT,
    OP_EM_LOAD,
    OP_EM_EMPTY
  } op_e;

  typedef enum logic [2:0] {
    RD_P,
    RD_R,
    RD_L,
    RD_PAR,
    RD_LAST,
    RD_K
  } rd_sel_e;

  typedef struct packed {
    op_e     op;
    rd_sel_e rd;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic rb_none;
    logic rb_last;
    logic par_gt;
    logic sd_done;
    logic em_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/mhbir_dp.sv =====
// ----------------------------------------------------------------------------
// mhbir_dp
// Heap datapath: item store, count, sift-down registers, rebuild and emit
// counters, capacity register and the output register.
// ----------------------------------------------------------------------------
module mhbir_dp #(
  parameter int unsigned DEPTH = mhbir_pkg::DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mhbir_pkg::cmd_t                      cmd_i,
  output mhbir_pkg::sts_t                      sts_o,
  input  logic signed [mhbir_pkg::DATA_W-1:0]  value_i,
  input  logic                                 cfg_we_i,
  input  logic        [mhbir_pkg::CAP_W-1:0]   cfg_wdata_i,
  output logic signed [mhbir_pkg::DATA_W-1:0]  item_o,
  output logic                                 valid_res_o,
  output logic                                 last_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i
);
  import mhbir_pkg::*;

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned CIW = AW + 2;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] vp_q, vr_q, val_q;
  logic signed [DATA_W-1:0] item_q;
  logic                     valid_res_q, last_q, out_valid_q;
  logic [CW-1:0]            cnt_q, k_q;
  logic [AW-1:0]            p_q, i_q;
  logic [CAP_W-1:0]         cap_q;

  logic [CIW-1:0]           rgt, lft, cnt_x;
  logic                     r_ok, l_ok;
  logic [AW-1:0]            half_m1, big_idx, rd_addr, wr_addr;
  logic signed [DATA_W-1:0] best, wr_data;
  logic                     sd_done, wr_en;

  assign cnt_x   = CIW'(cnt_q);
  assign rgt     = {1'b0, p_q, 1'b0} + CIW'(2);
  assign lft     = {1'b0, p_q, 1'b0} + CIW'(1);
  assign r_ok    = rgt < cnt_x;
  assign l_ok    = lft < cnt_x;
  assign half_m1 = AW'((cnt_q >> 1) - CW'(1));

  // right child first, left wins only when strictly larger
  always_comb begin
    best    = vp_q;
    big_idx = p_q;
    if (r_ok && (vr_q > best)) begin
      best    = vr_q;
      big_idx = rgt[AW-1:0];
    end
    if (l_ok && (rdata_q > best)) begin
      best    = rdata_q;
      big_idx = lft[AW-1:0];
    end
  end
  assign sd_done = (big_idx == p_q);

  always_comb begin
    unique case (cmd_i.rd)
      RD_P:    rd_addr = p_q;
      RD_R:    rd_addr = r_ok ? rgt[AW-1:0] : p_q;
      RD_L:    rd_addr = l_ok ? lft[AW-1:0] : p_q;
      RD_PAR:  rd_addr = half_m1;
      RD_LAST: rd_addr = AW'(cnt_q - CW'(1));
      RD_K:    rd_addr = k_q[AW-1:0];
      default: rd_addr = p_q;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_q;
    wr_data = vp_q;
    unique case (cmd_i.op)
      OP_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = AW'(cnt_q);
        wr_data = value_i;
      end
      OP_RM_SWAP: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = rdata_q;
      end
      OP_SD_STEP: begin
        wr_en   = 1'b1;
        wr_data = sd_done ? vp_q : best;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_APPEND) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.op == OP_RM_SWAP) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.op == OP_EM_LOAD || cmd_i.op == OP_EM_EMPTY) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_APPEND:  val_q <= value_i;
      OP_RB_INIT: begin
        i_q <= half_m1;
        p_q <= half_m1;
      end
      OP_SD_CAPP: vp_q <= rdata_q;
      OP_SD_CAPR: vr_q <= rdata_q;
      OP_SD_STEP: begin
        if (!sd_done) begin
          p_q <= big_idx;
        end else if (i_q != '0) begin
          i_q <= i_q - AW'(1);
          p_q <= i_q - AW'(1);
        end
      end
      OP_EM_INIT: k_q <= '0;
      OP_EM_LOAD: begin
        item_q      <= rdata_q;
        valid_res_q <= 1'b1;
        last_q      <= (k_q + CW'(1)) == cnt_q;
        k_q         <= k_q + CW'(1);
      end
      OP_EM_EMPTY: begin
        item_q      <= '0;
        valid_res_q <= 1'b0;
        last_q      <= 1'b1;
      end
      default: ;
    endcase
  end

  assign sts_o.full     = (CAP_W'(cnt_q) >= cap_q) || (cnt_q >= CW'(DEPTH));
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.rb_none  = (cnt_q < CW'(2));
  assign sts_o.rb_last  = (i_q == '0);
  assign sts_o.par_gt   = (val_q > rdata_q);
  assign sts_o.sd_done  = sd_done;
  assign sts_o.em_last  = (k_q + CW'(1)) == cnt_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign item_o      = item_q;
  assign valid_res_o = valid_res_q;
  assign last_o      = last_q;
  assign out_valid_o = out_valid_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("item count above depth");

  a_no_append_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_APPEND) |-> !sts_o.full)
    else $error("append while full");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EM_LOAD || cmd_i.op == OP_EM_EMPTY) |-> sts_o.out_free)
    else $error("output register overwritten");

  a_sift_descends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SD_STEP && !sd_done) |=> (p_q > $past(p_q)))
    else $error("sift-down did not move to a child");

endmodule

// ===== src/mhbir_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhbir_ctrl
// Heap controller: decodes actions and sequences append, parent check,
// remove, bottom-up rebuild and emit over the datapath.
// ----------------------------------------------------------------------------
module mhbir_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       action_i,
  output logic             in_ready_o,
  input  mhbir_pkg::sts_t  sts_i,
  output mhbir_pkg::cmd_t  cmd_o
);
  import mhbir_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_REQ,
    S_INS_CMP,
    S_RM_REQ,
    S_RM_WR,
    S_RB_START,
    S_SD_REQ_P,
    S_SD_GET_P,
    S_SD_REQ_R,
    S_SD_GET_R,
    S_SD_CMP,
    S_EM_START,
    S_EM_EMPTY,
    S_EM_REQ,
    S_EM_LOAD
  } state_e;

  state_e  state_q, state_d;
  logic    emit_q, emit_d;
  action_e act;
  state_e  after_rb;

  assign act        = action_e'(action_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign after_rb   = emit_q ? S_EM_START : S_IDLE;

  always_comb begin
    state_d   = state_q;
    emit_d    = emit_q;
    cmd_o.op  = OP_NONE;
    cmd_o.rd  = RD_P;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (act)
            ACT_LOAD: begin
              if (!sts_i.full) cmd_o.op = OP_APPEND;
            end
            ACT_INSERT: begin
              if (!sts_i.full) begin
                cmd_o.op = OP_APPEND;
                if (!sts_i.empty) state_d = S_INS_REQ;
              end
            end
            ACT_REMOVE: begin
              if (!sts_i.empty) state_d = S_RM_REQ;
            end
            ACT_BUILD: begin
              emit_d  = 1'b1;
              state_d = S_RB_START;
            end
            default: ;
          endcase
        end
      end
      S_INS_REQ: begin
        cmd_o.rd = RD_PAR;
        state_d  = S_INS_CMP;
      end
      S_INS_CMP: begin
        emit_d  = 1'b0;
        state_d = sts_i.par_gt ? S_RB_START : S_IDLE;
      end
      S_RM_REQ: begin
        cmd_o.rd = RD_LAST;
        state_d  = S_RM_WR;
      end
      S_RM_WR: begin
        cmd_o.op = OP_RM_SWAP;
        emit_d   = 1'b0;
        state_d  = S_RB_START;
      end
      S_RB_START: begin
        if (sts_i.rb_none) begin
          state_d = after_rb;
        end else begin
          cmd_o.op = OP_RB_INIT;
          state_d  = S_SD_REQ_P;
        end
      end
      S_SD_REQ_P: begin
        cmd_o.rd = RD_P;
        state_d  = S_SD_GET_P;
      end
      S_SD_GET_P: begin
        cmd_o.op = OP_SD_CAPP;
        cmd_o.rd = RD_R;
        state_d  = S_SD_GET_R;
      end
      S_SD_REQ_R: begin
        cmd_o.rd = RD_R;
        state_d  = S_SD_GET_R;
      end
      S_SD_GET_R: begin
        cmd_o.op = OP_SD_CAPR;
        cmd_o.rd = RD_L;
        state_d  = S_SD_CMP;
      end
      S_SD_CMP: begin
        cmd_o.op = OP_SD_STEP;
        priority if (!sts_i.sd_done) state_d = S_SD_REQ_R;
        else if (sts_i.rb_last)      state_d = after_rb;
        else                         state_d = S_SD_REQ_P;
      end
      S_EM_START: begin
        if (sts_i.empty) begin
          state_d = S_EM_EMPTY;
        end else begin
          cmd_o.op = OP_EM_INIT;
          state_d  = S_EM_REQ;
        end
      end
      S_EM_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EM_EMPTY;
          state_d  = S_IDLE;
        end
      end
      S_EM_REQ: begin
        cmd_o.rd = RD_K;
        state_d  = S_EM_LOAD;
      end
      S_EM_LOAD: begin
        cmd_o.rd = RD_K;
        if (sts_i.out_free) begin
          cmd_o.op = OP_EM_LOAD;
          state_d  = sts_i.em_last ? S_IDLE : S_EM_REQ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

endmodule

// ===== src/max_heap_build_insert_remove.sv =====
// Load appends the item. Insert appends it and, unless the heap was empty,
// checks its parent and runs a rebuild when the item is larger. Remove moves
// the last item to the root and runs a rebuild. Rebuild sifts down each
// parent from the last one to the root through the single store read port.
// Build rebuilds, then emits results one at a time while the consumer keeps
// up. Reset: count 0, capacity 64, store contents undefined until written.
// ----------------------------------------------------------------------------
// max_heap_build_insert_remove
// Array-backed binary max-heap with load, insert, remove-max and
// build-and-emit actions over a valid/ready input and result channel.
// ----------------------------------------------------------------------------
module max_heap_build_insert_remove #(
  parameter int unsigned DEPTH = mhbir_pkg::DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [1:0]                    action_i,
  input  logic signed [mhbir_pkg::DATA_W-1:0]  value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [mhbir_pkg::DATA_W-1:0]  item_o,
  output logic                                 valid_res_o,
  output logic                                 last_o,
  input  logic                                 cfg_we_i,
  input  logic        [mhbir_pkg::CAP_W-1:0]   cfg_wdata_i
);
  import mhbir_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mhbir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mhbir_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_o      (item_o),
    .valid_res_o (valid_res_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule
